// ----- rtl/iuhb_pkg.sv -----
// Shared types and constants of the IPv4/UDP header builder.
package iuhb_pkg;

   localparam int unsigned HDR_WORDS     = 14;
   localparam int unsigned WORD_IDX_W    = $clog2(HDR_WORDS);
   localparam int unsigned IP_HDR_BYTES  = 20;
   localparam int unsigned UDP_HDR_BYTES = 8;
   localparam int unsigned POS_W         = $clog2(IP_HDR_BYTES + UDP_HDR_BYTES);
   localparam int unsigned CSR_IDX_W     = 4;
   localparam int unsigned CSR_DATA_W    = 32;

   localparam logic [7:0]  UDP_PROTOCOL  = 8'h11;
   localparam logic [7:0]  VERSION_IHL   = 8'h45;
   localparam logic [15:0] UDP_HDR_LEN   = 16'(UDP_HDR_BYTES);
   localparam logic [15:0] IP_HDR_LEN    = 16'(IP_HDR_BYTES);

   localparam logic [POS_W-1:0] LAST_POS_IP  = POS_W'(IP_HDR_BYTES - 1);
   localparam logic [POS_W-1:0] LAST_POS_UDP = POS_W'(IP_HDR_BYTES + UDP_HDR_BYTES - 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TYPE_OF_SERVICE     = 4'd0,
      CSR_TIME_TO_LIVE        = 4'd1,
      CSR_PROTOCOL_NUMBER     = 4'd2,
      CSR_FLAG_BITS           = 4'd3,
      CSR_SOURCE_ADDRESS      = 4'd4,
      CSR_DESTINATION_ADDRESS = 4'd5,
      CSR_SOURCE_PORT         = 4'd6,
      CSR_DESTINATION_PORT    = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic [7:0]  type_of_service;
      logic [7:0]  time_to_live;
      logic [7:0]  protocol_number;
      logic [2:0]  flag_bits;
      logic [31:0] source_address;
      logic [31:0] destination_address;
      logic [15:0] source_port;
      logic [15:0] destination_port;
   } cfg_type;

   typedef struct packed {
      logic [15:0] payload_length;
      logic [15:0] identification;
      logic [12:0] fragment_offset;
      logic [15:0] udp_checksum;
   } item_type;

   typedef logic [HDR_WORDS-1:0][15:0] hdr_words_type;

   typedef struct packed {
      hdr_words_type words;
      logic          has_udp;
   } hdr_type;

endpackage

// ----- rtl/iuhb_build.sv -----
// Combinational assembly of the header words and the IPv4 header checksum.
module iuhb_build
   import iuhb_pkg::*;
(
   input  item_type item,
   input  cfg_type  cfg,
   output hdr_type  hdr
);

   logic [15:0] udp_len;
   logic [15:0] total_len;
   logic [15:0] flags_frag;
   logic [19:0] sum;
   logic [16:0] fold1;
   logic [15:0] fold2;

   always_comb begin
      udp_len    = item.payload_length + UDP_HDR_LEN;
      total_len  = udp_len + IP_HDR_LEN;
      flags_frag = {cfg.flag_bits, item.fragment_offset};

      // The checksum word itself counts as zero, so nine words are summed.
      sum = 20'({VERSION_IHL, cfg.type_of_service}) + 20'(total_len)
          + 20'(item.identification) + 20'(flags_frag)
          + 20'({cfg.time_to_live, cfg.protocol_number})
          + 20'(cfg.source_address[31:16]) + 20'(cfg.source_address[15:0])
          + 20'(cfg.destination_address[31:16])
          + 20'(cfg.destination_address[15:0]);
      // Two end-around folds are enough for a 20-bit sum.
      fold1 = 17'(sum[15:0]) + 17'(sum[19:16]);
      fold2 = fold1[15:0] + 16'(fold1[16]);

      hdr.words[0]  = {VERSION_IHL, cfg.type_of_service};
      hdr.words[1]  = total_len;
      hdr.words[2]  = item.identification;
      hdr.words[3]  = flags_frag;
      hdr.words[4]  = {cfg.time_to_live, cfg.protocol_number};
      hdr.words[5]  = ~fold2;
      hdr.words[6]  = cfg.source_address[31:16];
      hdr.words[7]  = cfg.source_address[15:0];
      hdr.words[8]  = cfg.destination_address[31:16];
      hdr.words[9]  = cfg.destination_address[15:0];
      hdr.words[10] = cfg.source_port;
      hdr.words[11] = cfg.destination_port;
      hdr.words[12] = udp_len;
      hdr.words[13] = item.udp_checksum;
      hdr.has_udp   = (cfg.protocol_number == UDP_PROTOCOL);
   end

endmodule

// ----- rtl/iuhb_serializer.sv -----
// Header word store and byte counter that stream one header byte per cycle while rsp_ready is high.
module iuhb_serializer
   import iuhb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load_valid,
   output logic       load_ready,
   input  hdr_type    load_hdr,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_byte
);

   hdr_words_type    words_ff, words_in;
   logic             has_udp_ff, has_udp_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             emitting_ff, emitting_in;
   logic [15:0]      word;
   logic             last;
   logic             load;

   always_comb begin
      word          = words_ff[pos_ff[POS_W-1:1]];
      rsp_out_byte  = pos_ff[0] ? word[7:0] : word[15:8];
      last          = has_udp_ff ? (pos_ff == LAST_POS_UDP) : (pos_ff == LAST_POS_IP);
      rsp_last_byte = last;
      rsp_valid     = emitting_ff;
      // A new header may enter while the last byte of the previous one leaves.
      load_ready    = !emitting_ff || (rsp_ready && last);
      load          = load_ready && load_valid;

      words_in    = words_ff;
      has_udp_in  = has_udp_ff;
      pos_in      = pos_ff;
      emitting_in = emitting_ff;
      if (load) begin
         words_in    = load_hdr.words;
         has_udp_in  = load_hdr.has_udp;
         pos_in      = '0;
         emitting_in = 1'b1;
      end else if (emitting_ff && rsp_ready) begin
         pos_in = pos_ff + 1'b1;
         if (last) begin
            pos_in      = '0;
            emitting_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         emitting_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         emitting_ff <= emitting_in;
      end
      words_ff   <= words_in;
      has_udp_ff <= has_udp_in;
   end

endmodule

// ----- rtl/ipv4_udp_header_builder_unit.sv -----
// Top level of the IPv4/UDP header builder: settings registers, input register and streamer.
//
// This block turns each accepted item (payload length, identification, fragment
// offset and UDP checksum) into a packet header sent one byte per cycle, while
// rsp_ready is high, in network order on the rsp channel, with rsp_last_byte marking
// the final byte. When the protocol register holds 17 the run is 28 bytes (20-byte
// IPv4 header plus 8-byte UDP header); otherwise it is the 20 IPv4 bytes only, and
// the total length field still counts the UDP header. Lengths wrap modulo 2^16. The
// header checksum is computed in hardware over the ten IPv4 words. Throughput is set
// by the one-byte output; a queued item is loaded into the word store as the last
// byte of the previous run leaves, so runs follow back to back. An item accepted into
// an idle block passes through the input register and then the streamer's word store
// before its first byte appears. One item is held in the input register while the
// previous header is still streaming, so req_ready stays high until that register is
// full. Settings registers are written through csr_* with no wait; they must only be
// changed while no item is in flight. Indexes above 7 are ignored.
module ipv4_udp_header_builder_unit
   import iuhb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [15:0]           req_payload_length,
   input  logic [15:0]           req_identification,
   input  logic [12:0]           req_fragment_offset,
   input  logic [15:0]           req_udp_checksum,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_last_byte,

   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   cfg_type  cfg_ff, cfg_in;
   item_type item_ff, item_in;
   logic     item_valid_ff, item_valid_in;
   logic     load_ready;
   hdr_type  hdr;

   // Settings registers. Each write keeps only the low bits of the register's width.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_TYPE_OF_SERVICE:     cfg_in.type_of_service     = csr_write_data[7:0];
            CSR_TIME_TO_LIVE:        cfg_in.time_to_live        = csr_write_data[7:0];
            CSR_PROTOCOL_NUMBER:     cfg_in.protocol_number     = csr_write_data[7:0];
            CSR_FLAG_BITS:           cfg_in.flag_bits           = csr_write_data[2:0];
            CSR_SOURCE_ADDRESS:      cfg_in.source_address      = csr_write_data;
            CSR_DESTINATION_ADDRESS: cfg_in.destination_address = csr_write_data;
            CSR_SOURCE_PORT:         cfg_in.source_port         = csr_write_data[15:0];
            CSR_DESTINATION_PORT:    cfg_in.destination_port    = csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   // The input register takes a new item whenever it is empty or is being handed
   // to the streamer in this same cycle.
   always_comb begin
      req_ready     = !item_valid_ff || load_ready;
      item_in       = item_ff;
      item_valid_in = item_valid_ff && !load_ready;
      if (req_valid && req_ready) begin
         item_in.payload_length  = req_payload_length;
         item_in.identification  = req_identification;
         item_in.fragment_offset = req_fragment_offset;
         item_in.udp_checksum    = req_udp_checksum;
         item_valid_in           = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.type_of_service     <= 8'd0;
         cfg_ff.time_to_live        <= 8'd1;
         cfg_ff.protocol_number     <= UDP_PROTOCOL;
         cfg_ff.flag_bits           <= 3'd2;
         cfg_ff.source_address      <= '0;
         cfg_ff.destination_address <= '0;
         cfg_ff.source_port         <= '0;
         cfg_ff.destination_port    <= '0;
         item_valid_ff              <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         item_valid_ff <= item_valid_in;
      end
      item_ff <= item_in;
   end

   // Header words and checksum are formed between the input register and the
   // streamer's word store.
   iuhb_build u_build (
      .item (item_ff),
      .cfg  (cfg_ff),
      .hdr  (hdr)
   );

   iuhb_serializer u_serializer (
      .clock         (clock),
      .reset         (reset),
      .load_valid    (item_valid_ff),
      .load_ready    (load_ready),
      .load_hdr      (hdr),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

endmodule

// ----- rtl/iuhb_checker.sv -----
// Port-level checks of the IPv4/UDP header builder and their attachment to the top level.
module iuhb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_byte
);

   // A stalled byte holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
                                  && $stable(rsp_last_byte))
      else $error("result item changed while stalled");

   // Nothing is offered right after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // An idle streamer always has room for an input item.
   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while output idle");

   // A header run never breaks off before its last byte.
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_byte |=> rsp_valid)
      else $error("header run broke off before its last byte");

endmodule

bind ipv4_udp_header_builder_unit iuhb_checker u_iuhb_checker (.*);
